### sv/ptac_pkg.sv
// shared types and constants for the pwm tracking adc controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptac_pkg;

   localparam int LEVEL_W   = 8;
   localparam int COUNT_W   = 4;
   localparam int CHAN_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;
   localparam int REQ_DAT_W = 8;
   localparam int RSP_DAT_W = 24;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN      = 8'd0;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 4'd15;
   localparam logic [LEVEL_W-1:0] RESULT_RESET   = 8'h80;
   localparam logic [LEVEL_W-1:0] OFFSET_RESET   = 8'd4;
   localparam logic [COUNT_W-1:0] CROSSING_RESET = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_APPROACH_OFFSET  = 1'b0,
      CSR_CROSSINGS_NEEDED = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

endpackage

`default_nettype wire

### sv/pwm_tracking_adc_controller.sv
// pwm-dac tracking adc controller: per-channel results, up/down level tracking
// depends on ptac_pkg
// response: registered, presented in the cycle after its accepted request beat
// throughput: one item per cycle unless rsp_tready stalls the response; the state update
// is a single pass of saturating step and crossing compare ahead of the response register
// reset: synchronous, clears tracking state, sets every stored result to 0x80
// and the csr registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module pwm_tracking_adc_controller #(
   parameter int CHANNELS = 3
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // kind
   input  wire                                   req_tuser,
   // channel[1:0], comparator_high[2], zero fill
   input  wire  [ptac_pkg::REQ_DAT_W-1:0]        req_tdata,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // conversion_done[0], dac_level[8:1], pwm_active[9], sample_value[17:10], zero fill
   output logic [ptac_pkg::RSP_DAT_W-1:0]        rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [ptac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [ptac_pkg::CSR_DAT_W-1:0]        csr_data
);

   logic [ptac_pkg::LEVEL_W-1:0] result_ff [CHANNELS];
   logic [ptac_pkg::LEVEL_W-1:0] result_in [CHANNELS];
   logic [ptac_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [ptac_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         prev_ff, prev_in;
   logic                         enable_ff, enable_in;
   logic [ptac_pkg::LEVEL_W-1:0] offset_ff;
   logic [ptac_pkg::COUNT_W-1:0] needed_ff;
   logic                         rsp_valid_ff;
   logic [ptac_pkg::RSP_DAT_W-1:0] rsp_data_ff, rsp_data_in;

   logic                         req_beat;
   ptac_pkg::kind_type           kind;
   logic [ptac_pkg::CHAN_W-1:0]  chan;
   logic                         comp_raw, comp;
   logic                         chan_ok;
   logic [ptac_pkg::LEVEL_W-1:0] stored, stored_after, sample;
   logic                         at_rail, finish, done;
   logic [ptac_pkg::LEVEL_W-1:0] step_level;
   logic [ptac_pkg::COUNT_W-1:0] step_count;

   assign kind     = ptac_pkg::kind_type'(req_tuser);
   assign chan     = req_tdata[1:0];
   assign comp_raw = req_tdata[2];
   assign chan_ok  = int'(chan) < CHANNELS;
   assign comp     = chan_ok & comp_raw;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      stored = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(chan) == i) begin
            stored = result_ff[i];
         end
      end
   end

   // saturating step and crossing count
   always_comb begin
      if (comp) begin
         at_rail    = level_ff == ptac_pkg::LEVEL_MAX;
         step_level = level_ff + 8'd1;
      end else begin
         at_rail    = level_ff == ptac_pkg::LEVEL_MIN;
         step_level = level_ff - 8'd1;
      end
      if (comp != prev_ff && count_ff < ptac_pkg::COUNT_MAX) begin
         step_count = count_ff + 4'd1;
      end else begin
         step_count = count_ff;
      end
   end

   always_comb begin
      level_in     = level_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      enable_in    = enable_ff;
      finish       = 1'b0;
      done         = 1'b0;
      stored_after = stored;
      for (int i = 0; i < CHANNELS; i++) begin
         result_in[i] = result_ff[i];
      end
      case (kind)
         ptac_pkg::KIND_START: begin
            if (chan_ok) begin
               level_in  = (stored > offset_ff) ? stored - offset_ff : ptac_pkg::LEVEL_MIN;
               count_in  = '0;
               enable_in = 1'b1;
            end
         end
         default: begin
            if (enable_ff) begin
               if (!at_rail) begin
                  level_in = step_level;
                  count_in = step_count;
                  prev_in  = comp;
               end
               finish = at_rail || (!at_rail && step_count >= needed_ff);
               if (finish) begin
                  count_in  = '0;
                  enable_in = 1'b0;
                  done      = 1'b1;
                  if (chan_ok) begin
                     stored_after = level_in;
                  end
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (chan_ok && int'(chan) == i) begin
                        result_in[i] = level_in;
                     end
                  end
               end
            end
         end
      endcase
      sample      = chan_ok ? stored_after : '0;
      rsp_data_in = {6'd0, sample, enable_in, level_in, done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            result_ff[i] <= ptac_pkg::RESULT_RESET;
         end
         level_ff     <= '0;
         count_ff     <= '0;
         prev_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            for (int i = 0; i < CHANNELS; i++) begin
               result_ff[i] <= result_in[i];
            end
            level_ff  <= level_in;
            count_ff  <= count_in;
            prev_ff   <= prev_in;
            enable_ff <= enable_in;
         end
         if (req_beat) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= ptac_pkg::OFFSET_RESET;
         needed_ff <= ptac_pkg::CROSSING_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (ptac_pkg::csr_index_type'(csr_index))
            ptac_pkg::CSR_APPROACH_OFFSET:  offset_ff <= csr_data;
            ptac_pkg::CSR_CROSSINGS_NEEDED: needed_ff <= csr_data[ptac_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // a finished conversion never leaves pwm running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> !rsp_data_ff[9])
      else $error("done beat with pwm still active");

   // crossings are only counted while a conversion runs
   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> enable_ff)
      else $error("crossing count nonzero while idle");

   // tracking state only moves on an accepted request beat; checked here for the end of a conversion
   assert property (@(posedge clock) disable iff (reset)
      $fell(enable_ff) |-> $past(req_beat))
      else $error("conversion ended without a request beat");

   // a response appears only after a request beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_beat))
      else $error("response without request");

   // the response register reports the live level
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_data_ff[8:1] == level_ff)
      else $error("response level differs from tracking level");

endmodule

`default_nettype wire
